>>> src/lra_pkg.sv
package lra_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 16;
    localparam int CAP_W    = 17;
    localparam int LG_W     = 5;
    localparam int EB_W     = 13;
    localparam int MINR_W   = 31;
    localparam int OFFO_W   = 31;
    localparam int REGO_W   = 32;
    localparam int CFGD_W   = 31;
    localparam int STAT_W   = 3;

    typedef logic [STAT_W-1:0] t_status;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic              t_cfg_idx;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_EXISTS  = 3'd1;
    localparam t_status ST_MISSING = 3'd2;
    localparam t_status ST_ZERO    = 3'd3;
    localparam t_status ST_FULL    = 3'd4;
    localparam t_status ST_LIMIT   = 3'd5;

    localparam t_mode MODE_CREATE = 2'd0;
    localparam t_mode MODE_RESIZE = 2'd1;
    localparam t_mode MODE_APPEND = 2'd2;

    localparam t_cfg_idx CFG_ENTRY_BYTES = 1'b0;
    localparam t_cfg_idx CFG_MIN_REGION  = 1'b1;

    localparam logic [CAP_W-1:0]  MAX_USED   = 17'd65535;
    localparam logic [EB_W-1:0]   EB_RESET   = 13'd8;
    localparam logic [MINR_W-1:0] MINR_RESET = 31'd4096;

endpackage

>>> src/list_region_allocator.sv
// Channel  | handshake                  | payload
// input    | i_in_valid / o_in_stall    | i_mode, i_list_id, i_entry_count
// output   | o_out_valid / i_out_stall  | o_status .. o_region_bytes
// config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// After reset a clearing pass writes every list entry before the first word is taken;
// configuration writes are taken throughout.
// A request runs, as needed, a release merge pass, a first-fit scan, the growth steps that
// double the region and a removal shift.
// A create skips the merge pass. Refusals found from the list entry alone skip all of
// these passes.
// A finished word waits in the output register while the next word is accepted; the
// block accepts no new word until the previous result has left for that register.
module list_region_allocator
    import lra_pkg::*;
#(
    parameter int LIST_COUNT  = 256,
    parameter int SPAN_SLOTS  = 64,
    parameter int REGION_BITS = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ID_W-1:0]      i_list_id,
    input  logic [CNT_W-1:0]     i_entry_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [OFFO_W-1:0]    o_new_offset,
    output logic [OFFO_W-1:0]    o_old_offset,
    output logic [CAP_W-1:0]     o_capacity,
    output logic [CNT_W-1:0]     o_used_count,
    output logic [CNT_W-1:0]     o_copy_count,
    output logic                 o_moved,
    output logic [REGO_W-1:0]    o_region_bytes,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [CFGD_W-1:0]    i_cfg_data
);

    localparam int IB  = $clog2(SPAN_SLOTS);
    localparam int CW  = $clog2(SPAN_SLOTS + 2);
    localparam int LB  = $clog2(LIST_COUNT);
    localparam int XW  = (LB > ID_W) ? LB : ID_W;
    localparam int OW  = REGION_BITS;
    localparam int LW  = REGION_BITS + 1;
    localparam int VW  = (REGION_BITS + 2 > 32) ? REGION_BITS + 2 : 32;
    localparam int FDW = OW + LW;
    localparam int LDW = 1 + OW + LG_W + CNT_W;
    localparam logic [VW-1:0] LIMIT = {{(VW-1){1'b0}}, 1'b1} << REGION_BITS;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_REL, S_FIT, S_GROW, S_TAKE, S_SHIFT, S_DONE
    } t_state;

    function automatic logic [LG_W-1:0] ceil_lg(input logic [CAP_W-1:0] x);
        logic [CAP_W-1:0] m;
        logic [LG_W-1:0]  r;
        m = x - 17'd1;
        r = '0;
        for (int i = 0; i < CAP_W; i++) begin
            if (m[i]) r = LG_W'(i + 1);
        end
        return r;
    endfunction

    t_state          r_state, n_state;
    logic [LB-1:0]   r_clr, n_clr;
    logic            r_bank, n_bank;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [VW-1:0]   r_region, n_region;
    logic [EB_W-1:0] r_eb, n_eb;
    logic [MINR_W-1:0] r_minr, n_minr;

    t_mode           r_mode, n_mode;
    logic [LB-1:0]   r_id, n_id;
    logic [CNT_W-1:0] r_n, n_n;
    logic            r_idok, n_idok;
    logic [OW-1:0]   r_cur_off, n_cur_off;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_tgt, n_tgt;
    logic [LG_W-1:0] r_tlg, n_tlg;
    logic            r_rel, n_rel;
    logic [VW-1:0]   r_need, n_need;
    logic [VW-1:0]   r_rel_off, n_rel_off;
    logic [VW-1:0]   r_rel_len, n_rel_len;

    logic            r_rb, n_rb;
    logic            r_wb, n_wb;
    logic [CW-1:0]   r_wc, n_wc;
    logic [VW-1:0]   r_wr, n_wr;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_widx, n_widx;
    logic            r_pv, n_pv;
    logic            r_pins, n_pins;
    logic            r_insd, n_insd;
    logic [VW-1:0]   r_poff, n_poff;
    logic [VW-1:0]   r_plen, n_plen;
    logic            r_tail, n_tail;
    logic [VW-1:0]   r_toff, n_toff;
    logic [VW-1:0]   r_tlen, n_tlen;
    logic [CW-1:0]   r_k, n_k;
    logic [VW-1:0]   r_koff, n_koff;
    logic [VW-1:0]   r_klen, n_klen;
    logic [VW-1:0]   r_size, n_size;
    logic [VW-1:0]   r_want, n_want;

    t_status         r_rst, n_rst;
    logic [OW-1:0]   r_rnew, n_rnew;
    logic [OW-1:0]   r_rold, n_rold;
    logic [CAP_W-1:0] r_rcap, n_rcap;
    logic [CNT_W-1:0] r_rused, n_rused;
    logic [CNT_W-1:0] r_rcopy, n_rcopy;
    logic            r_rmv, n_rmv;

    logic            r_ov, n_ov;
    t_status         r_ost, n_ost;
    logic [OFFO_W-1:0] r_onew, n_onew;
    logic [OFFO_W-1:0] r_oold, n_oold;
    logic [CAP_W-1:0] r_ocap, n_ocap;
    logic [CNT_W-1:0] r_oused, n_oused;
    logic [CNT_W-1:0] r_ocopy, n_ocopy;
    logic            r_omv, n_omv;
    logic [REGO_W-1:0] r_oreg, n_oreg;

    logic            f_we;
    logic [IB:0]     f_waddr, f_raddr;
    logic [FDW-1:0]  f_wdata, f_rdata;
    logic            l_we;
    logic [LB-1:0]   l_waddr, l_raddr;
    logic [LDW-1:0]  l_wdata, l_rdata;

    logic [VW-1:0]   e_off, e_len;
    logic [XW-1:0]   in_id_ext;
    logic            accept;

    assign e_off     = VW'(f_rdata[FDW-1:LW]);
    assign e_len     = VW'(f_rdata[LW-1:0]);
    assign in_id_ext = XW'(i_list_id);
    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign f_raddr   = {n_rb, n_idx[IB-1:0]};
    assign l_raddr   = accept ? in_id_ext[LB-1:0] : r_id;

    lra_ram #(.AW(IB + 1), .DW(FDW)) u_free (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    lra_ram #(.AW(LB), .DW(LDW)) u_list (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        logic             lv, ex, have_e, commit;
        logic [OW-1:0]    l_off;
        logic [LG_W-1:0]  l_lg;
        logic [CNT_W-1:0] l_used;
        logic [CAP_W-1:0] tgt, cap;
        logic [CW-1:0]    cwc;
        logic [VW-1:0]    base;

        n_state = r_state;   n_clr = r_clr;       n_bank = r_bank;   n_cnt = r_cnt;
        n_region = r_region; n_eb = r_eb;         n_minr = r_minr;
        n_mode = r_mode;     n_id = r_id;         n_n = r_n;         n_idok = r_idok;
        n_cur_off = r_cur_off; n_used = r_used;   n_tgt = r_tgt;     n_tlg = r_tlg;
        n_rel = r_rel;       n_need = r_need;     n_rel_off = r_rel_off;
        n_rel_len = r_rel_len;
        n_rb = r_rb;         n_wb = r_wb;         n_wc = r_wc;       n_wr = r_wr;
        n_idx = r_idx;       n_widx = r_widx;     n_pv = r_pv;       n_pins = r_pins;
        n_insd = r_insd;     n_poff = r_poff;     n_plen = r_plen;
        n_tail = r_tail;     n_toff = r_toff;     n_tlen = r_tlen;
        n_k = r_k;           n_koff = r_koff;     n_klen = r_klen;
        n_size = r_size;     n_want = r_want;
        n_rst = r_rst;       n_rnew = r_rnew;     n_rold = r_rold;   n_rcap = r_rcap;
        n_rused = r_rused;   n_rcopy = r_rcopy;   n_rmv = r_rmv;
        n_ost = r_ost;       n_onew = r_onew;     n_oold = r_oold;   n_ocap = r_ocap;
        n_oused = r_oused;   n_ocopy = r_ocopy;   n_omv = r_omv;     n_oreg = r_oreg;
        n_ov = r_ov && i_out_stall;

        f_we = 1'b0;
        f_waddr = {r_wb, r_k[IB-1:0]};
        f_wdata = {r_koff[OW-1:0], r_klen[LW-1:0]};
        l_we = 1'b0;
        l_waddr = r_id;
        l_wdata = {1'b1, r_cur_off, r_tlg, r_tgt};

        lv     = l_rdata[LDW-1];
        l_off  = r_idok ? l_rdata[LDW-2 -: OW] : '0;
        l_lg   = l_rdata[CNT_W +: LG_W];
        l_used = r_idok ? l_rdata[CNT_W-1:0] : '0;
        ex     = r_idok && lv;
        cap    = ex ? (17'd1 << l_lg) : '0;
        tgt    = (r_mode == MODE_RESIZE) ? {1'b0, r_n} : ({1'b0, l_used} + {1'b0, r_n});
        have_e = 1'b0;
        commit = 1'b0;
        cwc    = r_wc;
        base   = VW'((r_minr == '0) ? 31'd1 : r_minr);

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRY_BYTES: n_eb = i_cfg_data[EB_W-1:0];
                CFG_MIN_REGION:  n_minr = i_cfg_data[MINR_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLR: begin
                l_we = 1'b1;
                l_waddr = r_clr;
                l_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == LB'(LIST_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_id    = in_id_ext[LB-1:0];
                    n_n     = i_entry_count;
                    n_idok  = (32'(i_list_id) < LIST_COUNT);
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cur_off = l_off;
                n_used    = l_used;
                n_rst     = ST_OK;
                n_rnew    = l_off;
                n_rold    = l_off;
                n_rcap    = cap;
                n_rused   = l_used;
                n_rcopy   = '0;
                n_rmv     = 1'b0;
                n_state   = S_DONE;
                n_wb = r_bank;  n_wc = r_cnt;  n_wr = r_region;
                n_idx = '0;     n_rb = r_bank; n_tail = 1'b0;
                n_widx = '0;    n_pv = 1'b0;   n_insd = 1'b0;   n_pins = 1'b0;
                case (r_mode)
                    MODE_CREATE: begin
                        if (ex) n_rst = ST_EXISTS;
                        else if (!r_idok) n_rst = ST_MISSING;
                        else if (r_n == '0) n_rst = ST_ZERO;
                        else begin
                            n_tgt   = r_n;
                            n_tlg   = ceil_lg({1'b0, r_n});
                            n_need  = VW'(r_eb == '0 ? 13'd1 : r_eb) << ceil_lg({1'b0, r_n});
                            n_rel   = 1'b0;
                            n_state = S_FIT;
                        end
                    end
                    MODE_RESIZE, MODE_APPEND: begin
                        if (!ex) n_rst = ST_MISSING;
                        else if (r_n == '0) n_rst = ST_ZERO;
                        else if (tgt > MAX_USED) n_rst = ST_LIMIT;
                        else if (!(tgt <= (cap >> 1) || tgt > cap)) begin
                            // Still fits and not shrunk by half: only the used count moves.
                            l_we    = 1'b1;
                            l_wdata = {1'b1, l_off, l_lg, tgt[CNT_W-1:0]};
                            n_rused = tgt[CNT_W-1:0];
                        end else begin
                            n_tgt     = tgt[CNT_W-1:0];
                            n_tlg     = ceil_lg(tgt);
                            n_need    = VW'(r_eb == '0 ? 13'd1 : r_eb) << ceil_lg(tgt);
                            n_rel_off = VW'(l_off);
                            n_rel_len = VW'(r_eb == '0 ? 13'd1 : r_eb) << l_lg;
                            n_rel     = 1'b1;
                            n_state   = S_REL;
                        end
                    end
                    default: ;
                endcase
            end
            S_REL: begin
                // Merge copy into the other bank, inserting the freed block in order.
                have_e = r_idx < r_cnt;
                f_waddr = {~r_bank, r_widx[IB-1:0]};
                f_wdata = {r_poff[OW-1:0], r_plen[LW-1:0]};
                if (!r_insd && (!have_e || e_off > r_rel_off)) begin
                    if (r_pv && (r_poff + r_plen == r_rel_off)) begin
                        n_plen = r_plen + r_rel_len;
                    end else begin
                        if (r_pv) begin
                            f_we = 1'b1;
                            n_widx = r_widx + 1'b1;
                        end
                        n_poff = r_rel_off;
                        n_plen = r_rel_len;
                        n_pv = 1'b1;
                    end
                    n_pins = 1'b1;
                    n_insd = 1'b1;
                end else if (have_e) begin
                    if (r_pv && r_pins && (r_poff + r_plen == e_off)) begin
                        n_plen = r_plen + e_len;
                    end else begin
                        if (r_pv) begin
                            f_we = 1'b1;
                            n_widx = r_widx + 1'b1;
                        end
                        n_poff = e_off;
                        n_plen = e_len;
                        n_pv = 1'b1;
                    end
                    n_pins = 1'b0;
                    n_idx = r_idx + 1'b1;
                end else if (r_pv) begin
                    f_we = 1'b1;
                    n_widx = r_widx + 1'b1;
                    n_pv = 1'b0;
                end else if (r_widx > CW'(SPAN_SLOTS)) begin
                    n_rst = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_wb = ~r_bank;
                    n_wc = r_widx;
                    n_rb = ~r_bank;
                    n_idx = '0;
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                have_e = r_idx < r_wc;
                if (have_e) begin
                    if (r_idx == r_wc - 1'b1) begin
                        n_tail = (e_off + e_len == r_wr);
                        n_toff = e_off;
                        n_tlen = e_len;
                    end
                    if (e_len >= r_need) begin
                        n_k = r_idx;
                        n_koff = e_off;
                        n_klen = e_len;
                        n_state = S_TAKE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_size = (r_wr == '0) ? base : r_wr;
                    n_want = r_need - (r_tail ? r_tlen : '0);
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if ((r_size - r_wr < r_want) && (r_size <= LIMIT)) begin
                    n_size = r_size << 1;
                end else if (r_size > LIMIT) begin
                    n_rst = ST_LIMIT;
                    n_state = S_DONE;
                end else if (r_tail) begin
                    n_k = r_wc - 1'b1;
                    n_koff = r_toff;
                    n_klen = r_tlen + (r_size - r_wr);
                    n_wr = r_size;
                    n_state = S_TAKE;
                end else if (r_wc >= CW'(SPAN_SLOTS)) begin
                    n_rst = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_k = r_wc;
                    n_koff = r_wr;
                    n_klen = r_size - r_wr;
                    n_wc = r_wc + 1'b1;
                    n_wr = r_size;
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                if (r_klen == r_need) begin
                    if (r_k == r_wc - 1'b1) begin
                        commit = 1'b1;
                        cwc = r_wc - 1'b1;
                    end else begin
                        n_idx = r_k + 1'b1;
                        n_rb = r_wb;
                        n_state = S_SHIFT;
                    end
                end else begin
                    f_we = 1'b1;
                    f_wdata = {OW'(r_koff + r_need), LW'(r_klen - r_need)};
                    commit = 1'b1;
                end
            end
            S_SHIFT: begin
                if (r_idx < r_wc) begin
                    f_we = 1'b1;
                    f_waddr = {r_wb, r_idx[IB-1:0] - 1'b1};
                    f_wdata = f_rdata;
                    n_idx = r_idx + 1'b1;
                end else begin
                    commit = 1'b1;
                    cwc = r_wc - 1'b1;
                end
            end
            S_DONE: begin
                if (!(r_ov && i_out_stall)) begin
                    n_ov    = 1'b1;
                    n_ost   = r_rst;
                    n_onew  = OFFO_W'(r_rnew);
                    n_oold  = OFFO_W'(r_rold);
                    n_ocap  = r_rcap;
                    n_oused = r_rused;
                    n_ocopy = r_rcopy;
                    n_omv   = r_rmv;
                    n_oreg  = r_region[REGO_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (commit) begin
            n_bank   = r_wb;
            n_cnt    = cwc;
            n_region = r_wr;
            l_we     = 1'b1;
            l_wdata  = {1'b1, r_koff[OW-1:0], r_tlg, r_tgt};
            n_rnew   = r_koff[OW-1:0];
            n_rold   = r_rel ? r_cur_off : '0;
            n_rcap   = 17'd1 << r_tlg;
            n_rused  = r_tgt;
            n_rcopy  = r_rel ? ((r_used < r_tgt) ? r_used : r_tgt) : '0;
            n_rmv    = r_rel;
            n_state  = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_region <= '0;
            r_eb     <= EB_RESET;
            r_minr   <= MINR_RESET;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_bank   <= n_bank;
            r_cnt    <= n_cnt;
            r_region <= n_region;
            r_eb     <= n_eb;
            r_minr   <= n_minr;
            r_ov     <= n_ov;
        end
        r_mode <= n_mode;       r_id <= n_id;           r_n <= n_n;
        r_idok <= n_idok;       r_cur_off <= n_cur_off; r_used <= n_used;
        r_tgt <= n_tgt;         r_tlg <= n_tlg;         r_rel <= n_rel;
        r_need <= n_need;       r_rel_off <= n_rel_off; r_rel_len <= n_rel_len;
        r_rb <= n_rb;           r_wb <= n_wb;           r_wc <= n_wc;
        r_wr <= n_wr;           r_idx <= n_idx;         r_widx <= n_widx;
        r_pv <= n_pv;           r_pins <= n_pins;       r_insd <= n_insd;
        r_poff <= n_poff;       r_plen <= n_plen;       r_tail <= n_tail;
        r_toff <= n_toff;       r_tlen <= n_tlen;       r_k <= n_k;
        r_koff <= n_koff;       r_klen <= n_klen;       r_size <= n_size;
        r_want <= n_want;
        r_rst <= n_rst;         r_rnew <= n_rnew;       r_rold <= n_rold;
        r_rcap <= n_rcap;       r_rused <= n_rused;     r_rcopy <= n_rcopy;
        r_rmv <= n_rmv;
        r_ost <= n_ost;         r_onew <= n_onew;       r_oold <= n_oold;
        r_ocap <= n_ocap;       r_oused <= n_oused;     r_ocopy <= n_ocopy;
        r_omv <= n_omv;         r_oreg <= n_oreg;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_ov;
    assign o_status       = r_ost;
    assign o_new_offset   = r_onew;
    assign o_old_offset   = r_oold;
    assign o_capacity     = r_ocap;
    assign o_used_count   = r_oused;
    assign o_copy_count   = r_ocopy;
    assign o_moved        = r_omv;
    assign o_region_bytes = r_oreg;

endmodule

>>> src/lra_ram.sv
module lra_ram #(
    parameter int AW = 7,
    parameter int DW = 63
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lra_checker.sv
module lra_checker
    import lra_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [CAP_W-1:0]  o_capacity,
    input logic [CNT_W-1:0]  o_used_count,
    input logic [CNT_W-1:0]  o_copy_count,
    input logic              o_moved
);

    // A stalled result word holds its status and moved flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_moved))
        else $error("stalled result changed");

    // A refused request moves nothing.
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> !o_moved && (o_copy_count == '0))
        else $error("refused request reports a move");

    // Entries copied never exceed what the list now holds.
    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_moved |-> (o_status == ST_OK) && (o_copy_count <= o_used_count))
        else $error("copy count out of bounds");

    // Used entries fit in the capacity and the capacity is a power of two or zero.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_used_count} <= o_capacity) && $onehot0(o_capacity))
        else $error("used count exceeds capacity");

endmodule

bind list_region_allocator lra_checker u_lra_checker (.*);

>>> sim/list_region_allocator_chk.sv
module list_region_allocator_chk
    import lra_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [ID_W-1:0]      i_list_id,
    input  logic [CNT_W-1:0]     i_entry_count,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [STAT_W-1:0]    i_status,
    input  logic [OFFO_W-1:0]    i_new_offset,
    input  logic [OFFO_W-1:0]    i_old_offset,
    input  logic [CAP_W-1:0]     i_capacity,
    input  logic [CNT_W-1:0]     i_used_count,
    input  logic [CNT_W-1:0]     i_copy_count,
    input  logic                 i_moved,
    input  logic [REGO_W-1:0]    i_region_bytes,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [CFGD_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int NLISTS = 256;
    localparam int NSLOTS = 64;
    localparam longint unsigned AREA_LIMIT = 64'd1 << 31;

    typedef struct {
        longint unsigned off;
        longint unsigned len;
    } t_span;

    typedef struct {
        t_status            status;
        logic [OFFO_W-1:0]  new_off;
        logic [OFFO_W-1:0]  old_off;
        logic [CAP_W-1:0]   cap;
        logic [CNT_W-1:0]   used;
        logic [CNT_W-1:0]   copy;
        logic               moved;
        logic [REGO_W-1:0]  region;
    } t_alloc_result;

    t_span           free_spans[NSLOTS];
    int              free_num;
    bit              list_live[NLISTS];
    longint unsigned list_off[NLISTS];
    int unsigned     list_cap[NLISTS];
    int unsigned     list_used[NLISTS];
    longint unsigned area_size;
    logic [EB_W-1:0]   entry_size;
    logic [MINR_W-1:0] first_area;

    // Scratch copy of the allocator state; committed only on success.
    t_span           scr_spans[NSLOTS];
    int              scr_num;
    longint unsigned scr_area;

    t_alloc_result   awaited_results[$];

    assign o_pending = awaited_results.size();

    initial begin
        o_fail_count = 0;
        free_num = 0;
        area_size = 0;
        entry_size = EB_RESET;
        first_area = MINR_RESET;
        for (int i = 0; i < NLISTS; i++) begin
            list_live[i] = 0;
            list_off[i] = 0;
            list_cap[i] = 0;
            list_used[i] = 0;
        end
    end

    function automatic int free_block(longint unsigned off, longint unsigned len);
        int r;
        bit join_l, join_r;
        r = 0;
        while (r < scr_num && scr_spans[r].off <= off)
            r++;
        join_l = r > 0 && scr_spans[r-1].off + scr_spans[r-1].len == off;
        join_r = r < scr_num && off + len == scr_spans[r].off;
        if (join_l && join_r) begin
            scr_spans[r-1].len += len + scr_spans[r].len;
            for (int k = r; k < scr_num - 1; k++)
                scr_spans[k] = scr_spans[k+1];
            scr_num--;
        end else if (join_l) begin
            scr_spans[r-1].len += len;
        end else if (join_r) begin
            scr_spans[r].off -= len;
            scr_spans[r].len += len;
        end else begin
            if (scr_num >= NSLOTS)
                return ST_FULL;
            for (int k = scr_num; k > r; k--)
                scr_spans[k] = scr_spans[k-1];
            scr_spans[r].off = off;
            scr_spans[r].len = len;
            scr_num++;
        end
        return ST_OK;
    endfunction

    function automatic int find_fit(longint unsigned need);
        for (int i = 0; i < scr_num; i++)
            if (scr_spans[i].len >= need)
                return i;
        return -1;
    endfunction

    function automatic int carve_block(longint unsigned need, output longint unsigned where);
        int i;
        longint unsigned grow, want;
        bit tail;
        where = 0;
        i = find_fit(need);
        if (i < 0) begin
            grow = (scr_area == 0) ? ((first_area == 0) ? 1 : first_area) : scr_area;
            want = need;
            tail = scr_num > 0 &&
                scr_spans[scr_num-1].off + scr_spans[scr_num-1].len == scr_area;
            if (tail)
                want -= scr_spans[scr_num-1].len;
            while (grow - scr_area < want && grow <= AREA_LIMIT)
                grow *= 2;
            if (grow > AREA_LIMIT)
                return ST_LIMIT;
            if (grow > scr_area) begin
                if (tail) begin
                    scr_spans[scr_num-1].len += grow - scr_area;
                end else begin
                    if (scr_num >= NSLOTS)
                        return ST_FULL;
                    scr_spans[scr_num].off = scr_area;
                    scr_spans[scr_num].len = grow - scr_area;
                    scr_num++;
                end
                scr_area = grow;
            end
            i = find_fit(need);
            if (i < 0)
                return ST_LIMIT;
        end
        where = scr_spans[i].off;
        if (scr_spans[i].len == need) begin
            for (int k = i; k < scr_num - 1; k++)
                scr_spans[k] = scr_spans[k+1];
            scr_num--;
        end else begin
            scr_spans[i].off += need;
            scr_spans[i].len -= need;
        end
        return ST_OK;
    endfunction

    function automatic int unsigned round_pow2(int unsigned n);
        int unsigned p;
        p = 1;
        while (p < n)
            p <<= 1;
        return p;
    endfunction

    function automatic t_alloc_result place_request(t_mode mode, int unsigned id,
                                                    int unsigned n);
        t_alloc_result res;
        longint unsigned eb, cur_off, old_off, new_off, where;
        int unsigned cap, used, copy, c, target;
        bit live, moved;
        int st;
        eb = (entry_size == 0) ? 1 : entry_size;
        live = list_live[id];
        cur_off = list_off[id];
        cap = list_cap[id];
        used = list_used[id];
        old_off = cur_off;
        new_off = cur_off;
        copy = 0;
        moved = 0;
        st = ST_OK;
        scr_spans = free_spans;
        scr_num = free_num;
        scr_area = area_size;
        if (mode == MODE_CREATE) begin
            if (live)
                st = ST_EXISTS;
            else if (n == 0)
                st = ST_ZERO;
            else begin
                c = round_pow2(n);
                st = carve_block(longint'(c) * eb, where);
                if (st == ST_OK) begin
                    list_live[id] = 1;
                    list_off[id] = where;
                    list_cap[id] = c;
                    list_used[id] = n;
                    old_off = 0;
                    new_off = where;
                    cap = c;
                    used = n;
                end
            end
        end else if (mode == MODE_RESIZE || mode == MODE_APPEND) begin
            target = (mode == MODE_RESIZE) ? n : used + n;
            if (!live)
                st = ST_MISSING;
            else if (n == 0)
                st = ST_ZERO;
            else if (target > MAX_USED)
                st = ST_LIMIT;
            else if (target > cap / 2 && target <= cap) begin
                list_used[id] = target;
                used = target;
            end else begin
                c = round_pow2(target);
                st = free_block(cur_off, longint'(cap) * eb);
                if (st == ST_OK)
                    st = carve_block(longint'(c) * eb, where);
                if (st == ST_OK) begin
                    copy = (used < target) ? used : target;
                    moved = 1;
                    list_off[id] = where;
                    list_cap[id] = c;
                    list_used[id] = target;
                    new_off = where;
                    cap = c;
                    used = target;
                end
            end
        end
        if (st == ST_OK) begin
            free_spans = scr_spans;
            free_num = scr_num;
            area_size = scr_area;
        end
        res.status = t_status'(st);
        res.new_off = new_off[OFFO_W-1:0];
        res.old_off = old_off[OFFO_W-1:0];
        res.cap = cap[CAP_W-1:0];
        res.used = used[CNT_W-1:0];
        res.copy = copy[CNT_W-1:0];
        res.moved = moved;
        res.region = area_size[REGO_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (i_status !== exp_res.status)
                        report_mismatch("status", i_status, exp_res.status);
                    if (i_new_offset !== exp_res.new_off)
                        report_mismatch("new_offset", i_new_offset, exp_res.new_off);
                    if (i_old_offset !== exp_res.old_off)
                        report_mismatch("old_offset", i_old_offset, exp_res.old_off);
                    if (i_capacity !== exp_res.cap)
                        report_mismatch("capacity", i_capacity, exp_res.cap);
                    if (i_used_count !== exp_res.used)
                        report_mismatch("used_count", i_used_count, exp_res.used);
                    if (i_copy_count !== exp_res.copy)
                        report_mismatch("copy_count", i_copy_count, exp_res.copy);
                    if (i_moved !== exp_res.moved)
                        report_mismatch("moved", i_moved, exp_res.moved);
                    if (i_region_bytes !== exp_res.region)
                        report_mismatch("region_bytes", i_region_bytes, exp_res.region);
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.insert(awaited_results.size(),
                                       place_request(i_mode, i_list_id, i_entry_count));
        end
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ENTRY_BYTES)
                entry_size = i_cfg_data[EB_W-1:0];
            else
                first_area = i_cfg_data[MINR_W-1:0];
        end
    end

endmodule

>>> sim/list_region_allocator_tb.sv
module list_region_allocator_tb;
    import lra_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 300;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode;
    logic [ID_W-1:0]      i_list_id;
    logic [CNT_W-1:0]     i_entry_count;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [STAT_W-1:0]    o_status;
    logic [OFFO_W-1:0]    o_new_offset;
    logic [OFFO_W-1:0]    o_old_offset;
    logic [CAP_W-1:0]     o_capacity;
    logic [CNT_W-1:0]     o_used_count;
    logic [CNT_W-1:0]     o_copy_count;
    logic                 o_moved;
    logic [REGO_W-1:0]    o_region_bytes;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_idx;
    logic [CFGD_W-1:0]    i_cfg_data;

    int  fail_count;
    int  pending;
    int  cycle_count;
    bit  calm;

    list_region_allocator dut (.*);

    list_region_allocator_chk chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_list_id,
        .i_entry_count, .i_out_valid(o_out_valid), .i_out_stall, .i_status(o_status),
        .i_new_offset(o_new_offset), .i_old_offset(o_old_offset),
        .i_capacity(o_capacity), .i_used_count(o_used_count),
        .i_copy_count(o_copy_count), .i_moved(o_moved),
        .i_region_bytes(o_region_bytes), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("list_region_allocator_tb failed");
            $finish;
        end
    end

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < 23);

    // Valid stays high after an accepted word; the next call may drop it, set_register does.
    task automatic send_word(t_mode mode, logic [ID_W-1:0] id, logic [CNT_W-1:0] n);
        while (!calm && $urandom_range(99) < 23) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_mode <= mode;
        i_list_id <= id;
        i_entry_count <= n;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic set_register(t_cfg_idx idx, logic [CFGD_W-1:0] value);
        i_in_valid <= 0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_words(int count);
        t_mode mode;
        logic [ID_W-1:0] id;
        logic [CNT_W-1:0] n;
        int pick;
        for (int k = 0; k < count; k++) begin
            calm = (k >= count / 3) && (k < count / 3 + 30);
            pick = $urandom_range(99);
            mode = (pick < 4) ? t_mode'(3) : (pick < 30) ? MODE_CREATE :
                   (pick < 65) ? MODE_RESIZE : MODE_APPEND;
            id = ($urandom_range(99) < 80) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
            pick = $urandom_range(99);
            n = (pick < 3) ? '0 : (pick < 70) ? CNT_W'($urandom_range(40, 1)) :
                (pick < 90) ? CNT_W'($urandom_range(300, 1)) : CNT_W'($urandom);
            send_word(mode, id, n);
        end
        calm = 0;
    endtask

    initial begin
        cycle_count = 0;
        calm = 0;
        i_rst_n <= 0;
        i_in_valid <= 0;
        i_mode <= '0;
        i_list_id <= '0;
        i_entry_count <= '0;
        i_out_stall <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= CFG_ENTRY_BYTES;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: refusals, in-place updates, moves with merging and count overflow.
        send_word(MODE_CREATE, 8'd0, 16'd1);
        send_word(MODE_CREATE, 8'd0, 16'd5);
        send_word(MODE_CREATE, 8'd1, 16'd0);
        send_word(MODE_RESIZE, 8'd2, 16'd4);
        send_word(MODE_APPEND, 8'd2, 16'd4);
        send_word(MODE_CREATE, 8'd255, 16'hFFFF);
        send_word(MODE_CREATE, 8'd3, 16'd5);
        send_word(MODE_RESIZE, 8'd0, 16'd3);
        send_word(MODE_RESIZE, 8'd0, 16'd4);
        send_word(MODE_RESIZE, 8'd0, 16'd1);
        send_word(MODE_RESIZE, 8'd0, 16'd0);
        send_word(MODE_APPEND, 8'd3, 16'd3);
        send_word(MODE_APPEND, 8'd3, 16'hFFFF);
        send_word(MODE_APPEND, 8'd3, 16'd100);
        send_word(t_mode'(3), 8'd3, 16'hAAAA);
        send_word(MODE_RESIZE, 8'd255, 16'd1);
        send_word(MODE_RESIZE, 8'd3, 16'd2);
        send_word(MODE_CREATE, 8'd128, 16'h5555);
        send_word(MODE_APPEND, 8'd0, 16'd1);

        random_words(100);
        set_register(CFG_ENTRY_BYTES, 31'd1);
        set_register(CFG_MIN_REGION, 31'd1);
        random_words(100);
        set_register(CFG_ENTRY_BYTES, 31'd4096);
        set_register(CFG_MIN_REGION, 31'h4000_0000);
        send_word(MODE_CREATE, 8'd200, 16'hFFFF);
        send_word(MODE_CREATE, 8'd201, 16'hFFFF);
        random_words(100);
        set_register(CFG_ENTRY_BYTES, 31'd0);
        set_register(CFG_MIN_REGION, 31'd0);
        random_words(50);
        set_register(CFG_ENTRY_BYTES, 31'h7FFF_FFFF);
        set_register(CFG_MIN_REGION, 31'h7FFF_FFFF);
        random_words(50);

        i_in_valid <= 0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("list_region_allocator_tb passed");
        else
            $display("list_region_allocator_tb failed");
        $finish;
    end

endmodule

>>> sim.f
src/lra_pkg.sv
src/lra_ram.sv
src/list_region_allocator.sv
src/lra_checker.sv
sim/list_region_allocator_chk.sv
sim/list_region_allocator_tb.sv
